FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CHECK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

FILE: rtl/tbps_pkg.sv
// ----------------------------------------------------------------------------
// tbps_pkg
// Types, codes and sizes shared by the token bucket shaper files.
// ----------------------------------------------------------------------------
`default_nettype none

package tbps_pkg;

   // Wait queue sizing.
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   // Register port sizing.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_BUCKET_CAPACITY = 1'b0;
   localparam logic [15:0]            CAPACITY_RESET      = 16'd10;

   // Input opcodes.
   localparam logic OP_TOKEN_TICK = 1'b0;
   localparam logic OP_PACKET     = 1'b1;

   // Event codes.
   localparam logic [2:0] EV_TOKEN_ADDED   = 3'd0;
   localparam logic [2:0] EV_TOKEN_DROPPED = 3'd1;
   localparam logic [2:0] EV_TOO_BIG       = 3'd2;
   localparam logic [2:0] EV_QUEUED        = 3'd3;
   localparam logic [2:0] EV_QUEUE_FULL    = 3'd4;
   localparam logic [2:0] EV_RELEASED      = 3'd5;

   typedef struct packed {
      logic        opcode;
      logic [15:0] pkt_id;
      logic [15:0] tokens_needed;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [15:0] event_pkt_id;
      logic [15:0] tokens_now;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pkt_id;
      logic [15:0] tokens_needed;
   } queue_entry_type;

endpackage

`default_nettype wire

FILE: rtl/tbps_queue_ram.sv
// ----------------------------------------------------------------------------
// tbps_queue_ram
// Storage for waiting packets: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tbps_queue_ram
   import tbps_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [PTR_W-1:0] wr_addr,
   input  wire queue_entry_type wr_data,
   input  wire logic            rd_en,
   input  wire logic [PTR_W-1:0] rd_addr,
   output queue_entry_type      rd_data
);

   queue_entry_type mem [QUEUE_DEPTH];
   queue_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/token_bucket_packet_shaper_unit.sv
// Timing: an item's first result is registered out of the read step when the
// queue is empty after its own event, out of the decide step when packets wait there.
// Each packet released by that item adds another pass through the read and decide steps.
// The unit stays busy until it returns to idle with an item's last result and takes
// no new item meanwhile; the queue's single registered read port gives each release its own read step.
// Reset (synchronous): bucket empty, queue empty, capacity 10; no receiver stall.
// ----------------------------------------------------------------------------
// token_bucket_packet_shaper_unit
// Token bucket shaper with a FIFO of waiting packets held in a RAM.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module token_bucket_packet_shaper_unit
   import tbps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Command channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_item,
   // Result channel
   output logic                       rsp_valid,
   output rsp_type                    rsp_item,
   // Register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   // The sequencer walks each item through three steps. In the idle step
   // the item's own event is worked out and, for a queued packet, written
   // to the tail of the queue. The read step then looks at the queue: if
   // it is empty the pending result goes out as the last one, otherwise
   // the head entry is read. In the decide step the head's need is compared
   // with the bucket; a release sends the pending result and makes the
   // release itself the new pending result, and the read step runs again;
   // otherwise the pending result goes out as the last one. A result is therefore
   // held back by one step, until it is known whether another result follows it.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DECIDE
   } state_type;

   state_type       state_ff, state_in;
   logic [15:0]     capacity_ff, capacity_in;
   logic [15:0]     token_ff, token_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   rsp_type         pend_ff, pend_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_item_ff, rsp_item_in;

   logic            ram_wr_en;
   logic            ram_rd_en;
   queue_entry_type ram_wr_data;
   queue_entry_type ram_rd_data;

   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;

   // The tail and head pointers wrap at the queue depth, which need not be
   // a power of two.
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + PTR_W'(1);
      end
      return result;
   endfunction

   tbps_queue_ram u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // Register port: writes land in the access cycle, reads are immediate.
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      if (csr_index == REG_BUCKET_CAPACITY) begin
         prdata = {{(CSR_DATA_W - 16){1'b0}}, capacity_ff};
      end else begin
         prdata = '0;
      end
   end

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && (csr_index == REG_BUCKET_CAPACITY)) begin
         capacity_in = pwdata[15:0];
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign ram_wr_data = '{pkt_id: req_item.pkt_id,
                          tokens_needed: req_item.tokens_needed};

   always_comb begin
      state_in     = state_ff;
      token_in     = token_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in                = ST_READ;
               pend_in.last_of_run     = 1'b0;
               pend_in.event_pkt_id    = req_item.pkt_id;
               if (req_item.opcode == OP_TOKEN_TICK) begin
                  pend_in.event_pkt_id = '0;
                  if (token_ff < capacity_ff) begin
                     token_in           = token_ff + 16'd1;
                     pend_in.event_kind = EV_TOKEN_ADDED;
                  end else begin
                     pend_in.event_kind = EV_TOKEN_DROPPED;
                  end
               end else if (req_item.tokens_needed > capacity_ff) begin
                  pend_in.event_kind = EV_TOO_BIG;
               end else if (fill_ff == FILL_W'(QUEUE_DEPTH)) begin
                  pend_in.event_kind = EV_QUEUE_FULL;
               end else begin
                  ram_wr_en          = 1'b1;
                  tail_in            = next_slot(tail_ff);
                  fill_in            = fill_ff + FILL_W'(1);
                  pend_in.event_kind = EV_QUEUED;
               end
               pend_in.tokens_now = token_in;
            end
         end

         ST_READ: begin
            // The write of this item landed at the last edge, so reading
            // the head now cannot see stale data.
            if (fill_ff == '0) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in              = pend_ff;
               rsp_item_in.last_of_run  = 1'b1;
               state_in                 = ST_IDLE;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = pend_ff;
            if (token_ff >= ram_rd_data.tokens_needed) begin
               rsp_item_in.last_of_run = 1'b0;
               token_in                = token_ff - ram_rd_data.tokens_needed;
               head_in                 = next_slot(head_ff);
               fill_in                 = fill_ff - FILL_W'(1);
               pend_in.event_kind      = EV_RELEASED;
               pend_in.event_pkt_id    = ram_rd_data.pkt_id;
               pend_in.tokens_now      = token_in;
               pend_in.last_of_run     = 1'b0;
               state_in                = ST_READ;
            end else begin
               rsp_item_in.last_of_run = 1'b1;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAPACITY_RESET;
         token_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         token_ff     <= token_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // The fill count never passes the queue depth.
   `ASSERT_NEVER(a_fill_bound, clock, reset, fill_ff > FILL_W'(QUEUE_DEPTH), "queue overfilled")

   // An empty queue has its head and tail pointers together.
   `ASSERT_CHECK(a_empty_ptrs, clock, reset, fill_ff == '0 |-> head_ff == tail_ff, "pointers apart")

   // The last result of an item coincides with the return to idle, and any
   // other result with a release still under way.
   `ASSERT_CHECK(a_last, clock, reset, rsp_valid |-> busy != rsp_item.last_of_run, "last marker")

   // Results only follow a cycle in which an item was under way.
   `ASSERT_CHECK(a_rsp_from_busy, clock, reset, rsp_valid_ff |-> $past(busy), "result while idle")

endmodule

`default_nettype wire
